### rtl/core/hst_pkg.sv
package hst_pkg;

  // Table geometry
  localparam int SLOTS         = 1024;
  localparam int SLOT_BITS     = $clog2(SLOTS);
  localparam int ROW_BITS      = 32;
  localparam int ROWS          = SLOTS / ROW_BITS;
  localparam int ROW_ADDR_BITS = $clog2(ROWS);
  localparam int BIT_IDX_BITS  = $clog2(ROW_BITS);

  // Field widths
  localparam int ACTION_BITS   = 2;
  localparam int VALUE_BITS    = 64;
  localparam int HANDLE_BITS   = 21;
  localparam int STATUS_BITS   = 2;
  localparam int COUNT_BITS    = 10;

  // Handle encoding: handle = (slot + 1) * (2**HANDLE_SHIFT + 1)
  localparam int HANDLE_SHIFT  = 10;
  localparam int QUOT_BITS     = HANDLE_BITS - HANDLE_SHIFT;

  // Stream payload layout
  localparam int IN_ACT_LSB    = 0;
  localparam int IN_VAL_LSB    = IN_ACT_LSB + ACTION_BITS;
  localparam int IN_HDL_LSB    = IN_VAL_LSB + VALUE_BITS;
  localparam int IN_USED       = IN_HDL_LSB + HANDLE_BITS;
  localparam int IN_BITS       = ((IN_USED + 7) / 8) * 8;
  localparam int OUT_USED      = STATUS_BITS + HANDLE_BITS + VALUE_BITS + COUNT_BITS;
  localparam int OUT_BITS      = ((OUT_USED + 7) / 8) * 8;

  // Action codes
  localparam logic [ACTION_BITS-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_LOOKUP  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_RELEASE = 2'd2;

  // Status codes
  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_BAD  = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 ok;
    logic [SLOT_BITS-1:0] slot;
  } hdec_t;

  // q * (2**HANDLE_SHIFT + 1) as a shift and an add
  function automatic logic [HANDLE_BITS-1:0] stride_mul(input logic [QUOT_BITS-1:0] q);
    logic [HANDLE_BITS-1:0] sh;
    sh = {q, {HANDLE_SHIFT{1'b0}}};
    return sh + HANDLE_BITS'(q);
  endfunction

endpackage

### rtl/core/hst_handle_dec.sv
module hst_handle_dec (
  input  logic [hst_pkg::HANDLE_BITS-1:0] handle,
  output hst_pkg::hdec_t                  dec
);
  import hst_pkg::*;

  logic [QUOT_BITS-1:0] q0;
  logic [QUOT_BITS-1:0] q1;
  logic [QUOT_BITS-1:0] q;
  logic                 m0;
  logic                 m1;

  // The quotient is either the top bits or one less
  assign q0 = handle[HANDLE_BITS-1:HANDLE_SHIFT];
  assign q1 = q0 - 1'b1;
  assign m0 = (stride_mul(q0) == handle);
  assign m1 = (q0 != '0) && (stride_mul(q1) == handle);
  assign q  = m0 ? q0 : q1;

  assign dec.ok   = (m0 || m1) && (q != '0) &&
                    ({1'b0, q} <= (QUOT_BITS + 1)'(SLOTS));
  assign dec.slot = SLOT_BITS'(q - 1'b1);

endmodule

### rtl/core/handle_slot_table.sv
// Channel   Direction  Request contents (lowest bit first)
// s_*       in         action[1:0], stored_value[65:2], handle_number[86:66]
// m_*       out        status[1:0], handle_out[22:2], value_out[86:23], occupied[96:87]
//
// One request at a time. A lookup or release of a well-formed handle goes from accept
// through the check state to the done state; a malformed handle, an unknown action or
// an allocate refused as full goes straight to the done state. An allocate walks the
// occupancy map in the scan state, one 32-slot row after another (1 to 33 rows), set by
// the single row-scan unit and its one map read port. After reset the occupancy map is
// cleared one row a cycle, with s_tready low. A result waiting on m_tready does not hold
// off the next accept; it holds the following request in its last cycle until the
// output register is free.
module handle_slot_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [hst_pkg::IN_BITS-1:0]  s_tdata,   // action, stored_value, handle_number
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [hst_pkg::OUT_BITS-1:0] m_tdata    // status, handle_out, value_out, occupied
);
  import hst_pkg::*;

  state_t state, state_next;

  // Request fields
  logic [ACTION_BITS-1:0] in_action;
  logic [VALUE_BITS-1:0]  in_value;
  logic [HANDLE_BITS-1:0] in_handle;
  hdec_t                  dec;

  assign in_action = s_tdata[IN_VAL_LSB-1:IN_ACT_LSB];
  assign in_value  = s_tdata[IN_HDL_LSB-1:IN_VAL_LSB];
  assign in_handle = s_tdata[IN_USED-1:IN_HDL_LSB];

  hst_handle_dec u_dec (
    .handle (in_handle),
    .dec    (dec)
  );

  // Held request and control
  logic [ACTION_BITS-1:0]   act;
  logic [SLOT_BITS-1:0]     slot;
  logic [VALUE_BITS-1:0]    val_in;
  logic [ROW_ADDR_BITS-1:0] scan_row;
  logic [BIT_IDX_BITS-1:0]  start_bit;
  logic                     scan_first;
  logic [COUNT_BITS-1:0]    count;
  logic [SLOT_BITS-1:0]     last_slot;
  logic [ROW_ADDR_BITS-1:0] clr_row;
  logic [STATUS_BITS-1:0]   res_status;
  logic [HANDLE_BITS-1:0]   res_handle;
  logic [VALUE_BITS-1:0]    res_value;

  // Occupancy map: rows of used bits; value store: one word per slot
  logic [ROW_BITS-1:0]   used_mem [ROWS];
  logic [VALUE_BITS-1:0] val_mem  [SLOTS];
  logic [ROW_BITS-1:0]   used_rd;
  logic [VALUE_BITS-1:0] val_rd;

  logic                     accept;
  logic                     full;
  logic                     out_free;
  logic [SLOT_BITS-1:0]     start_slot;
  logic [ROW_ADDR_BITS-1:0] used_ra;
  logic                     used_we;
  logic [ROW_ADDR_BITS-1:0] used_wa;
  logic [ROW_BITS-1:0]      used_wd;
  logic                     val_we;
  logic [ROW_BITS-1:0]      scan_mask;
  logic [ROW_BITS-1:0]      free_bits;
  logic                     found;
  logic [BIT_IDX_BITS-1:0]  free_idx;
  logic [SLOT_BITS-1:0]     found_slot;
  logic                     slot_used;

  assign accept     = s_tvalid && s_tready;
  assign full       = (count >= COUNT_BITS'(SLOTS - 1));
  assign out_free   = !m_tvalid || m_tready;
  assign start_slot = last_slot + 1'b1;

  // Row-scan unit: first free slot in the row just read, masked below the start bit in the first row
  assign scan_mask = scan_first ? ({ROW_BITS{1'b1}} << start_bit) : {ROW_BITS{1'b1}};
  assign free_bits = ~used_rd & scan_mask;
  assign found     = (free_bits != '0);

  always_comb begin
    free_idx = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) free_idx = BIT_IDX_BITS'(i);
    end
  end

  assign found_slot = {scan_row, free_idx};
  assign slot_used  = used_rd[slot[BIT_IDX_BITS-1:0]];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_row == ROW_ADDR_BITS'(ROWS - 1)) state_next = S_IDLE;
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_action)
            ACT_ALLOC:   state_next = full ? S_DONE : S_SCAN;
            ACT_LOOKUP,
            ACT_RELEASE: state_next = dec.ok ? S_CHK : S_DONE;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_SCAN:  if (found) state_next = S_DONE;
      S_CHK:   state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Control outputs and memory ports
  always_comb begin
    s_tready = 1'b0;
    used_we  = 1'b0;
    used_wa  = scan_row;
    used_wd  = used_rd | (ROW_BITS'(1) << free_idx);
    val_we   = 1'b0;
    used_ra  = scan_row + 1'b1;
    unique case (state)
      S_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr_row;
        used_wd = '0;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        used_ra  = (in_action == ACT_ALLOC) ? start_slot[SLOT_BITS-1:BIT_IDX_BITS]
                                            : dec.slot[SLOT_BITS-1:BIT_IDX_BITS];
      end
      S_SCAN: begin
        used_we = found;
        val_we  = found;
      end
      S_CHK: begin
        used_we = (act == ACT_RELEASE) && slot_used;
        used_wa = slot[SLOT_BITS-1:BIT_IDX_BITS];
        used_wd = used_rd & ~(ROW_BITS'(1) << slot[BIT_IDX_BITS-1:0]);
      end
      S_DONE:  ;
      default: ;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_rd <= used_mem[used_ra];
  end

  always_ff @(posedge clk) begin
    if (val_we) val_mem[found_slot] <= val_in;
    val_rd <= val_mem[dec.slot];
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      count     <= '0;
      last_slot <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_row <= clr_row + 1'b1;

      if (accept) begin
        act        <= in_action;
        slot       <= dec.slot;
        val_in     <= in_value;
        scan_row   <= start_slot[SLOT_BITS-1:BIT_IDX_BITS];
        start_bit  <= start_slot[BIT_IDX_BITS-1:0];
        scan_first <= 1'b1;
        res_handle <= '0;
        res_value  <= '0;
        res_status <= ((in_action == ACT_ALLOC) && full) ? ST_FULL : ST_BAD;
      end

      // Advance the scan one row, or claim the free slot found
      if (state == S_SCAN) begin
        if (found) begin
          res_status <= ST_OK;
          res_handle <= stride_mul(QUOT_BITS'(found_slot) + 1'b1);
          count      <= count + 1'b1;
          last_slot  <= found_slot;
        end else begin
          scan_row   <= scan_row + 1'b1;
          scan_first <= 1'b0;
        end
      end

      if ((state == S_CHK) && slot_used) begin
        res_status <= ST_OK;
        if (act == ACT_LOOKUP) res_value <= val_rd;
        if (act == ACT_RELEASE) count <= count - 1'b1;
      end

      // Hand the result to the output register, or drop it once taken
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {(OUT_BITS - OUT_USED)'(0), count, res_value, res_handle, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(SLOTS - 1))
    else $error("occupancy count above table capacity");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) ||
                     count == COUNT_BITS'($past(count) + 1'b1) ||
                     count == COUNT_BITS'($past(count) - 1'b1)))
    else $error("occupancy count moved by more than one");

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is in progress");

endmodule

### test/slot_table_shadow_pkg.sv
`timescale 1ns / 1ps

package slot_table_shadow_pkg;
  import hst_pkg::*;

  // One result as it leaves on m_tdata, status in the lowest bits
  typedef struct packed {
    logic [COUNT_BITS-1:0]  occupied;
    logic [VALUE_BITS-1:0]  value;
    logic [HANDLE_BITS-1:0] handle;
    logic [STATUS_BITS-1:0] status;
  } table_reply_t;

  localparam int HANDLE_STRIDE = (1 << HANDLE_SHIFT) + 1;

  class slot_table_shadow;
    bit                    slot_used  [SLOTS];
    logic [VALUE_BITS-1:0] slot_value [SLOTS];
    int unsigned           occupied;
    int unsigned           last_slot;
    table_reply_t          expected_replies [$];

    int unsigned errors;
    int unsigned replies_seen;
    int unsigned requests;
    int unsigned n_alloc, n_full, n_lookup_hit, n_release, n_rejected, peak;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i]  = 1'b0;
        slot_value[i] = '0;
      end
      occupied     = 0;
      last_slot    = 0;
      errors       = 0;
      replies_seen = 0;
      requests     = 0;
      n_alloc      = 0;
      n_full       = 0;
      n_lookup_hit = 0;
      n_release    = 0;
      n_rejected   = 0;
      peak         = 0;
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction

    // Split a handle into its slot; false when it is not a stride multiple or out of range
    function bit decode(logic [HANDLE_BITS-1:0] h, output int unsigned slot);
      slot = 0;
      if (h == 0 || (h % HANDLE_STRIDE) != 0) return 1'b0;
      slot = h / HANDLE_STRIDE - 1;
      return slot < SLOTS;
    endfunction

    // Pick the handle of an occupied slot, or slot 0 when the table is empty
    function logic [HANDLE_BITS-1:0] live_handle();
      int unsigned s;
      if (occupied == 0) return HANDLE_BITS'(HANDLE_STRIDE);
      s = $urandom_range(0, SLOTS - 1);
      while (!slot_used[s]) s = (s + 1) % SLOTS;
      return HANDLE_BITS'((s + 1) * HANDLE_STRIDE);
    endfunction

    // Apply one accepted request to the shadow table and queue its result
    function void note_request(logic [ACTION_BITS-1:0] act, logic [VALUE_BITS-1:0] val,
                               logic [HANDLE_BITS-1:0] hdl);
      table_reply_t r;
      int unsigned  s;
      r        = '0;
      r.status = ST_BAD;
      requests++;
      case (act)
        ACT_ALLOC: begin
          if (occupied >= SLOTS - 1) begin
            r.status = ST_FULL;
            n_full++;
          end else begin
            s = (last_slot + 1) % SLOTS;
            while (slot_used[s]) s = (s + 1) % SLOTS;
            slot_used[s]  = 1'b1;
            slot_value[s] = val;
            occupied++;
            last_slot = s;
            r.status  = ST_OK;
            r.handle  = HANDLE_BITS'((s + 1) * HANDLE_STRIDE);
            n_alloc++;
          end
        end
        ACT_LOOKUP: begin
          if (decode(hdl, s) && slot_used[s]) begin
            r.status = ST_OK;
            r.value  = slot_value[s];
            n_lookup_hit++;
          end
        end
        ACT_RELEASE: begin
          if (decode(hdl, s) && slot_used[s]) begin
            slot_used[s]  = 1'b0;
            slot_value[s] = '0;
            if (occupied > 0) occupied--;
            r.status = ST_OK;
            n_release++;
          end
        end
        default: ;
      endcase
      if (r.status == ST_BAD) n_rejected++;
      if (occupied > peak) peak = occupied;
      r.occupied = COUNT_BITS'(occupied);
      expected_replies.push_back(r);
    endfunction

    task report(string line);
      errors++;
      // keep the log short when everything goes wrong at once
      if (errors <= 30) $display("mismatch: %s", line);
    endtask

    task check_result(logic [OUT_BITS-1:0] data);
      table_reply_t got, want;
      got = data[OUT_USED-1:0];
      replies_seen++;
      if (expected_replies.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", replies_seen));
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status)
          report($sformatf("result %0d status %0d, expected %0d",
                           replies_seen, got.status, want.status));
        if (got.handle !== want.handle)
          report($sformatf("result %0d handle %0d, expected %0d",
                           replies_seen, got.handle, want.handle));
        if (got.value !== want.value)
          report($sformatf("result %0d value %h, expected %h",
                           replies_seen, got.value, want.value));
        if (got.occupied !== want.occupied)
          report($sformatf("result %0d occupancy %0d, expected %0d",
                           replies_seen, got.occupied, want.occupied));
      end
    endtask
  endclass

endpackage

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import hst_pkg::*;
  import slot_table_shadow_pkg::*;

  // Action code that the block must reject
  localparam logic [ACTION_BITS-1:0] ACT_UNKNOWN = 2'd3;
  // Highest stride multiple that still fits the handle field
  localparam int TOP_MULTIPLE = (2 ** HANDLE_BITS - 1) / HANDLE_STRIDE;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata;   // action, stored_value, handle_number
  logic                m_tvalid;
  logic                m_tready;
  logic [OUT_BITS-1:0] m_tdata;   // status, handle_out, value_out, occupied

  // When set, both sides run flat out with no gaps
  bit quiet;

  slot_table_shadow shadow;

  handle_slot_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int unsigned pick_pause();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_BITS-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [HANDLE_BITS-1:0] slot_handle(int unsigned s);
    return HANDLE_BITS'((s + 1) * HANDLE_STRIDE);
  endfunction

  // Offer one request, hold it until accepted, then note it in the shadow table.
  // Leave s_tvalid high on acceptance so back-to-back requests need no second
  // assignment in the same step; lower it only when a gap follows.
  task automatic send_request(input logic [ACTION_BITS-1:0] act,
                              input logic [VALUE_BITS-1:0]  val,
                              input logic [HANDLE_BITS-1:0] hdl);
    int unsigned pause;
    pause = pick_pause();
    if (pause > 0) begin
      s_tvalid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_BITS'({hdl, val, act});
    do @(posedge clk); while (!s_tready);
    shadow.note_request(act, val, hdl);
  endtask

  // Result side: ready bursts broken by random stalls
  initial begin : result_sink
    int unsigned stall;
    forever begin
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_pause();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check every result as it leaves the block
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) shadow.check_result(m_tdata);
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned wait_cycles;
    bit          draining;
    shadow = new();
    quiet  = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table first, so lookup and release of a free slot fail
    send_request(ACT_LOOKUP, '1, slot_handle(0));
    send_request(ACT_RELEASE, '0, slot_handle(0));
    // Next-fit starts after slot 0; a zero value is still a stored value
    send_request(ACT_ALLOC, '0, '0);
    send_request(ACT_ALLOC, '1, '1);
    send_request(ACT_ALLOC, {$urandom, $urandom}, '0);
    send_request(ACT_LOOKUP, {$urandom, $urandom}, slot_handle(1));
    send_request(ACT_LOOKUP, '0, slot_handle(2));
    // Malformed handles: zero, all ones, slot past the end, off the stride
    send_request(ACT_LOOKUP, '0, '0);
    send_request(ACT_LOOKUP, '0, '1);
    send_request(ACT_LOOKUP, '0, slot_handle(SLOTS));
    send_request(ACT_LOOKUP, '0, slot_handle(1) + 1'b1);
    send_request(ACT_UNKNOWN, '1, slot_handle(1));
    // Release twice: the second must fail and leave the count alone
    send_request(ACT_RELEASE, '0, slot_handle(1));
    send_request(ACT_RELEASE, '0, slot_handle(1));
    send_request(ACT_LOOKUP, '0, slot_handle(1));
    send_request(ACT_RELEASE, '1, '0);
    send_request(ACT_LOOKUP, '0, slot_handle(SLOTS - 1));
    // The freed slot 1 is behind the pointer, so this lands in slot 4
    send_request(ACT_ALLOC, {$urandom, $urandom}, '0);
    send_request(ACT_RELEASE, '0, HANDLE_BITS'(TOP_MULTIPLE * HANDLE_STRIDE));
    send_request(ACT_LOOKUP, '0, slot_handle(3));

    // Fill to capacity; the scan wraps past the top slot on the way
    while (shadow.occupied < SLOTS - 1)
      send_request(ACT_ALLOC, random_value(), HANDLE_BITS'($urandom));
    repeat (3) send_request(ACT_ALLOC, random_value(), HANDLE_BITS'($urandom));
    send_request(ACT_LOOKUP, '0, slot_handle(SLOTS - 1));
    send_request(ACT_LOOKUP, '0, slot_handle(0));

    // Random traffic: alternate draining and refilling stretches, mostly
    // on live handles, with a share of malformed and stale requests
    for (int i = 0; i < 850; i++) begin
      quiet    = (i >= 300 && i < 400);
      draining = ((i / 170) % 2) == 0;
      pick     = $urandom_range(0, 99);
      if (pick < (draining ? 15 : 55)) begin
        send_request(ACT_ALLOC, random_value(), HANDLE_BITS'($urandom));
      end else if (pick < (draining ? 40 : 75)) begin
        send_request(ACT_LOOKUP, random_value(), shadow.live_handle());
      end else if (pick < (draining ? 80 : 85)) begin
        send_request(ACT_RELEASE, random_value(), shadow.live_handle());
      end else begin
        case ($urandom_range(0, 4))
          0: send_request(ACTION_BITS'($urandom_range(0, 3)), random_value(),
                          HANDLE_BITS'($urandom));
          1: send_request(ACT_UNKNOWN, random_value(), shadow.live_handle());
          2: send_request($urandom_range(0, 1) ? ACT_LOOKUP : ACT_RELEASE, random_value(),
                          HANDLE_BITS'($urandom_range(SLOTS + 1, TOP_MULTIPLE) * HANDLE_STRIDE));
          3: send_request($urandom_range(0, 1) ? ACT_LOOKUP : ACT_RELEASE, random_value(),
                          $urandom_range(0, 1) ? shadow.live_handle() + 1'b1
                                               : shadow.live_handle() - 1'b1);
          default: send_request($urandom_range(0, 1) ? ACT_LOOKUP : ACT_RELEASE,
                                random_value(), slot_handle($urandom_range(0, SLOTS - 1)));
        endcase
      end
    end

    // Drain: wait for every outstanding result, then allow a longest allocate
    s_tvalid <= 1'b0;
    quiet = 1'b0;
    wait_cycles = 0;
    while (shadow.pending() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (48) @(posedge clk);

    $display("Ran %0d requests: %0d allocations, %0d refused as full, %0d lookup hits, %0d releases,",
             shadow.requests, shadow.n_alloc, shadow.n_full, shadow.n_lookup_hit,
             shadow.n_release);
    $display("%0d rejected handles or actions; occupancy peaked at %0d, %0d results checked.",
             shadow.n_rejected, shadow.peak, shadow.replies_seen);
    if (shadow.pending() != 0)
      shadow.report($sformatf("%0d results never arrived", shadow.pending()));
    if (shadow.errors == 0) begin
      $display("[handle_slot_table] OK");
    end else begin
      $display("[handle_slot_table] ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #15000000;
    $display("[handle_slot_table] ERROR");
    $finish;
  end

endmodule
